// ===== sv/bffa_pkg.sv =====
// Shared types and constants for the bitmap first-fit allocator.
// No dependencies; imported by bffa_byte_unit, bitmap_first_fit_allocator and tb_top.
`default_nettype none

package bffa_pkg;

  // Request codes
  localparam logic [1:0] REQ_SEARCH = 2'd0;
  localparam logic [1:0] REQ_ALLOC  = 2'd1;
  localparam logic [1:0] REQ_FREE   = 2'd2;

  // Bit index / run counter width: the bits in use never exceed 255 * 8 = 2040,
  // and start plus run length never exceeds 1023 + 2047 = 3070.
  localparam int unsigned IDX_W = 12;

  localparam logic [7:0] MAP_BYTES_RESET = 8'd128;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_SCAN  = 3'b100
  } state_t;

  // Result of processing one map byte
  typedef struct packed {
    logic [7:0]       new_byte;
    logic             hit;
    logic [9:0]       where;
    logic [IDX_W-1:0] count_out;
  } byte_res_t;

endpackage

`default_nettype wire

// ===== sv/bffa_byte_unit.sv =====
// Shared per-byte unit: free-run counting for search, masked set/clear for marks.
// Depends on bffa_pkg.
`default_nettype none

module bffa_byte_unit import bffa_pkg::*; (
  input  wire logic [7:0]       data,
  input  wire logic [IDX_W-1:0] base,      // bit index of the byte's first bit
  input  wire logic [IDX_W-1:0] count_in,  // free run length before this byte
  input  wire logic [10:0]      run_len,
  input  wire logic [9:0]       lo_bit,    // first bit to mark
  input  wire logic [IDX_W-1:0] hi_bit,    // one past the last bit to mark
  input  wire logic [IDX_W-1:0] n_bits,    // bits in use
  input  wire logic             set_val,
  output byte_res_t             res
);

  logic [IDX_W-1:0] cnt [8];
  logic [7:0]       hitv;

  always_comb begin
    logic             blocked;
    logic [2:0]       last;
    logic [IDX_W-1:0] idx;
    res = '0;
    for (int j = 0; j < 8; j++) begin
      blocked = 1'b0;
      last    = 3'd0;
      for (int k = 0; k < 8; k++) begin
        if (k <= j && data[7-k]) begin
          blocked = 1'b1;
          last    = 3'(k);
        end
      end
      cnt[j] = blocked ? IDX_W'(3'(j) - last) : count_in + IDX_W'(j + 1);
      idx    = {base[IDX_W-1:3], 3'(j)};
      hitv[j] = (idx < n_bits) && (cnt[j] == {1'b0, run_len});
      if (idx >= {2'b00, lo_bit} && idx < hi_bit)
        res.new_byte[7-j] = set_val;
      else
        res.new_byte[7-j] = data[7-j];
    end
    // lowest hit wins
    for (int j = 7; j >= 0; j--) begin
      if (hitv[j]) begin
        res.hit   = 1'b1;
        res.where = 10'({base[IDX_W-1:3], 3'(j)} + IDX_W'(1) - {1'b0, run_len});
      end
    end
    res.count_out = cnt[7];
  end

endmodule

`default_nettype wire

// ===== sv/bitmap_first_fit_allocator.sv =====
// Bitmap first-fit allocator, top level: sequencer, map memory, result register.
// Depends on bffa_pkg and bffa_byte_unit.
// Sequencing: a search reads at most the bytes in use, one map byte a cycle through the shared
// byte unit, after the read and before the wind-down; marks read, modify and write back the
// bytes touched. A zero-length search, an empty or off-map mark or an unknown request answers from idle.
// One request at a time, next taken once back in idle; no stall. Reset clears the map first.
`default_nettype none

module bitmap_first_fit_allocator import bffa_pkg::*; #(
  parameter int unsigned MAP_BITS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  // request
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [9:0]  start_index,
  input  wire logic [10:0] run_length,
  // result
  output logic             done,
  output logic             found,
  output logic [9:0]       run_start
);

  // Map store geometry
  localparam int unsigned DEPTH = (MAP_BITS + 7) / 8;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data;

  state_t           state;
  logic [7:0]       map_bytes;
  logic [CW-1:0]    rd_cnt;     // next byte to read (also the clear pointer)
  logic [CW-1:0]    hi;         // one past the last byte to visit
  logic             pipe_v;     // rd_data holds a byte for this request
  logic [CW-1:0]    pipe_idx;   // byte address of rd_data
  logic [IDX_W-1:0] run_cnt;    // free run carried between bytes
  logic [1:0]       op;
  logic [9:0]       lo_bit;
  logic [IDX_W-1:0] hi_bit;
  logic [10:0]      len;

  // Bits in use: min(map_bytes * 8, MAP_BITS)
  logic [IDX_W-1:0] n_bits;
  logic [IDX_W-1:0] end_req;
  logic [IDX_W-1:0] end_clip;
  logic [IDX_W-1:0] lim;
  logic [IDX_W:0]   lim_up;
  logic             accept;
  logic             issue;
  logic             search_hit;
  byte_res_t        bres;

  always_comb begin
    if ((32'(map_bytes) * 32'd8) > 32'(MAP_BITS))
      n_bits = IDX_W'(MAP_BITS);
    else
      n_bits = IDX_W'({map_bytes, 3'b000});
    end_req  = IDX_W'(start_index) + IDX_W'(run_length);
    end_clip = (end_req > n_bits) ? n_bits : end_req;
    lim      = (req_type == REQ_SEARCH) ? n_bits : end_clip;
    lim_up   = ({1'b0, lim} + (IDX_W+1)'(7)) >> 3;
  end

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  // Shared byte unit works on the byte that the memory returned last cycle
  bffa_byte_unit u_byte (
    .data     (rd_data),
    .base     (IDX_W'({pipe_idx, 3'b000})),
    .count_in (run_cnt),
    .run_len  (len),
    .lo_bit   (lo_bit),
    .hi_bit   (hi_bit),
    .n_bits   (n_bits),
    .set_val  (op == REQ_ALLOC),
    .res      (bres)
  );

  assign search_hit = pipe_v && (op == REQ_SEARCH) && bres.hit;
  assign issue      = (state == S_SCAN) && (rd_cnt != hi) && !search_hit;

  // Map memory: one write port (clear or read-modify-write), one registered read
  always_ff @(posedge clk) begin
    if (state == S_CLEAR)
      mem[rd_cnt[AW-1:0]] <= 8'h00;
    else if (state == S_SCAN && pipe_v && op != REQ_SEARCH)
      mem[pipe_idx[AW-1:0]] <= bres.new_byte;
    if (issue)
      rd_data <= mem[rd_cnt[AW-1:0]];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst)
      map_bytes <= MAP_BYTES_RESET;
    else if (cfg_we)
      map_bytes <= cfg_wdata;
  end

  // Request payload, held for the whole request
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= req_type;
      lo_bit <= start_index;
      hi_bit <= end_clip;
      len    <= run_length;
    end
    if (issue)
      pipe_idx <= rd_cnt;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      rd_cnt  <= '0;
      hi      <= '0;
      pipe_v  <= 1'b0;
      run_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          rd_cnt <= rd_cnt + CW'(1);
          if (rd_cnt == CW'(DEPTH - 1))
            state <= S_IDLE;
        end
        S_IDLE: begin
          pipe_v  <= 1'b0;
          run_cnt <= '0;
          if (start) begin
            hi <= CW'(lim_up);
            case (req_type)
              REQ_SEARCH: begin
                if (run_length == 11'd0) begin
                  done      <= 1'b1;
                  found     <= 1'b1;
                  run_start <= '0;
                end else begin
                  rd_cnt <= '0;
                  state  <= S_SCAN;
                end
              end
              REQ_ALLOC, REQ_FREE: begin
                if (IDX_W'(start_index) < end_clip) begin
                  rd_cnt <= CW'(start_index[9:3]);
                  state  <= S_SCAN;
                end else begin
                  // range is empty or lies wholly outside the bits in use
                  done      <= 1'b1;
                  found     <= 1'b1;
                  run_start <= '0;
                end
              end
              default: begin
                done      <= 1'b1;
                found     <= 1'b0;
                run_start <= '0;
              end
            endcase
          end
        end
        S_SCAN: begin
          pipe_v <= issue;
          if (issue)
            rd_cnt <= rd_cnt + CW'(1);
          if (pipe_v)
            run_cnt <= bres.count_out;
          if (search_hit) begin
            done      <= 1'b1;
            found     <= 1'b1;
            run_start <= bres.where;
            state     <= S_IDLE;
          end else if (rd_cnt == hi && !pipe_v) begin
            // all bytes visited: marks succeed, a search has failed
            done      <= 1'b1;
            found     <= (op != REQ_SEARCH);
            run_start <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for bitmap_first_fit_allocator: directed and random search, allocate and
// free requests checked against a bit-level map predictor. Depends on bffa_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import bffa_pkg::*;

  // Request code the block does not know; it must answer not found and change nothing
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int unsigned PREDICT_BITS = 1024;
  // Longest stretch with no request, result or register write before giving up.
  // This comfortably covers a full scan and the reset clearing pass.
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic       found;
    logic [9:0] run_start;
  } answer_t;

  // A range handed out by a search-then-allocate sequence, kept for a later free
  typedef struct {
    logic [9:0]  first;
    logic [10:0] len;
  } extent_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        start = 1'b0;
  logic [1:0]  req_type = REQ_SEARCH;
  logic [9:0]  start_index = 10'd0;
  logic [10:0] run_length = 11'd0;
  logic        busy;
  logic        done;
  logic        found;
  logic [9:0]  run_start;

  // Predictor state: one bit per map bit, index 0 first, 1 = allocated
  bit          map_bits [PREDICT_BITS];
  logic [7:0]  map_bytes_cfg = MAP_BYTES_RESET;

  answer_t     pending_answers [$];
  answer_t     last_answer;
  extent_t     held_extents [$];
  int unsigned requests_sent = 0;
  int unsigned error_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned size_pick = 0;
  int unsigned stall_cycles = 0;

  // Register settings walked through by the random part; extremes included
  logic [7:0]  map_sizes [10] = '{8'd128, 8'd1, 8'd255, 8'd16, 8'd0,
                                  8'd64, 8'd127, 8'd2, 8'd128, 8'd8};

  bitmap_first_fit_allocator i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .start_index (start_index),
    .run_length  (run_length),
    .done        (done),
    .found       (found),
    .run_start   (run_start)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Bits taking part: eight per configured byte, capped at the map size
  function automatic int unsigned live_bits();
    int unsigned n;
    n = map_bytes_cfg * 8;
    return (n > PREDICT_BITS) ? PREDICT_BITS : n;
  endfunction

  // Works out the answer to one request and applies its effect on the map
  function automatic answer_t predict_answer(logic [1:0] kind, logic [9:0] first,
                                             logic [10:0] len);
    answer_t     ans;
    int unsigned n;
    int unsigned run;
    int unsigned stop;
    ans = '0;
    n = live_bits();
    case (kind)
      REQ_SEARCH: begin
        if (len == 0) begin
          // zero length: found at 0, even with no bytes in use
          ans.found = 1'b1;
        end else begin
          run = 0;
          for (int i = 0; i < n; i++) begin
            if (map_bits[i]) run = 0;
            else run++;
            if (run == len) begin
              ans.found = 1'b1;
              ans.run_start = 10'(i + 1 - len);
              break;
            end
          end
        end
      end
      REQ_ALLOC, REQ_FREE: begin
        // clipped at the bits in use, never wraps
        stop = first + len;
        if (stop > n) stop = n;
        for (int i = first; i < stop; i++) map_bits[i] = (kind == REQ_ALLOC);
        ans.found = 1'b1;
      end
      default: ;
    endcase
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endfunction

  // Results cannot be held off: take one on every strobe, compare with the oldest
  always @(posedge clk) begin : check_results
    answer_t want;
    if (!rst && done === 1'b1) begin
      if (pending_answers.size() == 0) begin
        flag_error($sformatf("result with no request waiting: found=%0b run_start=%0d",
                             found, run_start));
      end else begin
        want = pending_answers.pop_front();
        if (found !== want.found || run_start !== want.run_start)
          flag_error($sformatf("expected found=%0b run_start=%0d, got found=%0b run_start=%0d",
                               want.found, want.run_start, found, run_start));
      end
    end
  end

  // Watchdog: counts cycles with no request taken, no result and no register write
  always @(posedge clk) begin
    if ((start && !busy) || done === 1'b1 || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------

  // Offers one request, optionally after an idle gap, and waits for it to be taken.
  // start is left high so back-to-back requests need no extra edge.
  task automatic send_request(input logic [1:0] kind, input logic [9:0] first,
                              input logic [10:0] len);
    // each cycle the sender stays quiet with the given chance in a hundred
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    req_type    <= kind;
    start_index <= first;
    run_length  <= len;
    do @(posedge clk); while (busy !== 1'b0);
    last_answer = predict_answer(kind, first, len);
    pending_answers.push_back(last_answer);
    requests_sent++;
  endtask

  // Pause the sender until every outstanding request has answered
  task automatic wait_all_answered();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Register write, only once the block has gone idle
  task automatic set_map_bytes(input logic [7:0] value);
    wait_all_answered();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    map_bytes_cfg = value;
  endtask

  // Mostly short runs, some long, a few anywhere in the 11-bit range
  function automatic logic [10:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 11'($urandom_range(16, 1));
    if (r < 85) return 11'($urandom_range(128, 17));
    if (r < 95) return 11'($urandom_range(1024, 129));
    return 11'($urandom_range(2047));
  endfunction

  // Mostly inside the bits in use, sometimes anywhere
  function automatic logic [9:0] pick_start();
    if (live_bits() == 0 || $urandom_range(3) == 0) return 10'($urandom_range(1023));
    return 10'($urandom_range(live_bits() - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty map at full size: zero length, single bit, whole map, over-long run
  task automatic test_search_extremes();
    send_request(REQ_SEARCH, 10'd0, 11'd0);
    send_request(REQ_SEARCH, 10'd0, 11'd1);
    send_request(REQ_SEARCH, 10'd0, 11'd1024);
    send_request(REQ_SEARCH, 10'h3FF, 11'h7FF);
  endtask

  // Allocate and free at both ends, ranges running off the map, zero length
  task automatic test_range_marks();
    send_request(REQ_ALLOC, 10'd0, 11'd1);
    send_request(REQ_ALLOC, 10'd1023, 11'd1);
    send_request(REQ_SEARCH, 10'd0, 11'd1022);   // run ends one short of the last bit
    send_request(REQ_SEARCH, 10'd0, 11'd1023);
    send_request(REQ_FREE, 10'd0, 11'h7FF);      // clears everything, clipped
    send_request(REQ_ALLOC, 10'd1020, 11'd100);  // only the last four bits set
    send_request(REQ_SEARCH, 10'd0, 11'd1020);
    send_request(REQ_SEARCH, 10'd0, 11'd1021);
    send_request(REQ_ALLOC, 10'd0, 11'd0);
    send_request(REQ_FREE, 10'd1020, 11'd4);
  endtask

  task automatic test_unknown_request();
    send_request(REQ_UNKNOWN, 10'h3FF, 11'h7FF);
    send_request(REQ_UNKNOWN, 10'd0, 11'd0);
  endtask

  // Shrinking hides bits, growing reveals them; no bytes; size above the cap
  task automatic test_map_size_changes();
    set_map_bytes(8'd1);
    send_request(REQ_SEARCH, 10'd0, 11'd8);
    send_request(REQ_SEARCH, 10'd0, 11'd9);
    send_request(REQ_ALLOC, 10'd7, 11'd5);       // only bit 7 lands
    set_map_bytes(8'd0);
    send_request(REQ_SEARCH, 10'd0, 11'd0);
    send_request(REQ_SEARCH, 10'd0, 11'd1);
    send_request(REQ_ALLOC, 10'd0, 11'd10);      // nothing in use, nothing set
    set_map_bytes(8'd255);
    send_request(REQ_SEARCH, 10'd0, 11'd1024);   // bit 7 still set from above
    send_request(REQ_SEARCH, 10'd0, 11'd1016);
    send_request(REQ_FREE, 10'd0, 11'd8);
    set_map_bytes(8'd128);
  endtask

  // Allocator-like traffic: search then allocate what was found, free held
  // ranges later, with random searches, marks and unknown requests mixed in.
  // Each block of about a hundred runs under a fresh register setting.
  task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct);
    int unsigned goal;
    int unsigned pick;
    int unsigned k;
    logic [10:0] len;
    extent_t     ext;
    sender_idle_pct = idle_pct;
    goal = requests_sent + count;
    while (requests_sent < goal) begin
      if (size_pick % 10 == 9) set_map_bytes(8'($urandom_range(128, 1)));
      else set_map_bytes(map_sizes[size_pick % 10]);
      size_pick++;
      if ($urandom_range(2) == 0) begin
        send_request(REQ_FREE, 10'd0, 11'h7FF);
        held_extents.delete();
      end
      repeat (100) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          len = pick_length();
          send_request(REQ_SEARCH, 10'($urandom_range(1023)), len);
          if (last_answer.found && len != 0) begin
            ext.first = last_answer.run_start;
            ext.len   = len;
            send_request(REQ_ALLOC, ext.first, ext.len);
            held_extents.push_back(ext);
          end
        end else if (pick < 65 && held_extents.size() != 0) begin
          k = $urandom_range(held_extents.size() - 1);
          ext = held_extents[k];
          held_extents.delete(k);
          send_request(REQ_FREE, ext.first, ext.len);
        end else if (pick < 85) begin
          send_request(REQ_SEARCH, 10'($urandom_range(1023)), pick_length());
        end else if (pick < 95) begin
          send_request(($urandom_range(1) == 0) ? REQ_ALLOC : REQ_FREE,
                       pick_start(), pick_length());
        end else begin
          send_request(REQ_UNKNOWN, 10'($urandom_range(1023)),
                       11'($urandom_range(2047)));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // the map clearing pass holds busy high
    do @(posedge clk); while (busy !== 1'b0);

    test_search_extremes();
    test_range_marks();
    test_unknown_request();
    test_map_size_changes();

    // sender idles rarely, then often, then never
    test_random_traffic(630, 6);
    test_random_traffic(630, 73);
    test_random_traffic(630, 0);

    wait_all_answered();
    // room for a stray late strobe
    repeat (140) @(posedge clk);
    if (error_count == 0 && pending_answers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
